// File: design/pbp_pkg.sv
// Shared types, register indexes and saturation helper for the 2D Boris pusher.
// No dependencies; all design files but pbp_if.sv import this package.
package pbp_pkg;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_PUSH = 1'b1
  } op_t;

  typedef logic [7:0] reg_idx_t;
  localparam reg_idx_t REG_KICK  = 8'd0;
  localparam reg_idx_t REG_DRIFT = 8'd1;
  localparam reg_idx_t REG_ROT_T = 8'd2;
  localparam reg_idx_t REG_ROT_S = 8'd3;

  localparam int FRAC_ONE = 65536;

  typedef logic [22:0]        pos_t;
  typedef logic signed [23:0] vel_t;
  typedef logic signed [23:0] coef_t;
  typedef logic [23:0]        ucoef_t;
  typedef logic [16:0]        frac_t;
  typedef logic signed [24:0] efield_t;
  typedef logic signed [26:0] kick_t;

  typedef struct packed {
    vel_t fx;
    vel_t fy;
  } field_pair_t;

  // Per-particle sideband that travels down the pipeline with its valid bit.
  typedef struct packed {
    logic vld;
    pos_t px;
    pos_t py;
    vel_t vx;
    vel_t vy;
    logic last;
  } side_t;

  function automatic vel_t sat24(input logic signed [27:0] v);
    vel_t r;
    if (v > 28'sd8388607) begin
      r = 24'sh7FFFFF;
    end else if (v < -28'sd8388608) begin
      r = 24'sh800000;
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

endpackage

// File: design/pbp_if.sv
// Handshake interfaces for the particle channel, the result channel and the
// configuration write channel. Plain valid/ready, no dependencies.
interface pbp_in_if;
  logic               valid;
  logic               ready;
  logic               op;
  logic [12:0]        node_index;
  logic signed [23:0] field_x_in;
  logic signed [23:0] field_y_in;
  logic [22:0]        pos_x;
  logic [22:0]        pos_y;
  logic signed [23:0] vel_x;
  logic signed [23:0] vel_y;
  logic               last_in;
  modport source (output valid, op, node_index, field_x_in, field_y_in, pos_x, pos_y,
                  vel_x, vel_y, last_in, input ready);
  modport sink (input valid, op, node_index, field_x_in, field_y_in, pos_x, pos_y,
                vel_x, vel_y, last_in, output ready);
endinterface

interface pbp_out_if;
  logic               valid;
  logic               ready;
  logic [22:0]        new_pos_x;
  logic [22:0]        new_pos_y;
  logic signed [23:0] new_vel_x;
  logic signed [23:0] new_vel_y;
  logic               last_out;
  modport source (output valid, new_pos_x, new_pos_y, new_vel_x, new_vel_y, last_out,
                  input ready);
  modport sink (input valid, new_pos_x, new_pos_y, new_vel_x, new_vel_y, last_out,
                output ready);
endinterface

interface pbp_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [23:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: design/pbp_field_bank.sv
// One copy of the field store: one write port, one registered read port.
// Depends on pbp_pkg for the field pair type.
module pbp_field_bank #(
  parameter int DEPTH = 4225,
  parameter int AW    = 13
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic                 we,
  input  logic [AW-1:0]        waddr,
  input  pbp_pkg::field_pair_t wdata,
  input  logic [AW-1:0]        raddr,
  output pbp_pkg::field_pair_t rdata
);
  import pbp_pkg::*;

  field_pair_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (en) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: design/pbp_gather.sv
// Bilinear field gather: interpolate along y in one stage, along x in the next.
// Depends on pbp_pkg.
module pbp_gather (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  pbp_pkg::side_t       s_in,
  input  pbp_pkg::frac_t       di,
  input  pbp_pkg::frac_t       dj,
  input  pbp_pkg::field_pair_t f_a,
  input  pbp_pkg::field_pair_t f_a1,
  input  pbp_pkg::field_pair_t f_b,
  input  pbp_pkg::field_pair_t f_b1,
  output pbp_pkg::side_t       s_out,
  output pbp_pkg::efield_t     ex,
  output pbp_pkg::efield_t     ey
);
  import pbp_pkg::*;

  side_t              s2;
  frac_t              di2;
  logic signed [41:0] gax, gbx, gay, gby;
  logic signed [41:0] gax_next, gbx_next, gay_next, gby_next;
  logic signed [17:0] wy0, wy1, wx0, wx1;
  logic signed [59:0] accx, accy;
  efield_t            ex_next, ey_next;

  always_comb begin
    wy0 = $signed({1'b0, 17'(FRAC_ONE) - dj});
    wy1 = $signed({1'b0, dj});
    gax_next = f_a.fx * wy0 + f_a1.fx * wy1;
    gbx_next = f_b.fx * wy0 + f_b1.fx * wy1;
    gay_next = f_a.fy * wy0 + f_a1.fy * wy1;
    gby_next = f_b.fy * wy0 + f_b1.fy * wy1;
  end

  // Weights sum to 2^32, so the rounded sum fits the field width plus one.
  always_comb begin
    wx0 = $signed({1'b0, 17'(FRAC_ONE) - di2});
    wx1 = $signed({1'b0, di2});
    accx = gax * wx0 + gbx * wx1 + 60'sd2147483648;
    accy = gay * wx0 + gby * wx1 + 60'sd2147483648;
    ex_next = accx[56:32];
    ey_next = accy[56:32];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2.vld    <= 1'b0;
      s_out.vld <= 1'b0;
    end else if (en) begin
      s2    <= s_in;
      di2   <= di;
      gax   <= gax_next;
      gbx   <= gbx_next;
      gay   <= gay_next;
      gby   <= gby_next;
      s_out <= s2;
      ex    <= ex_next;
      ey    <= ey_next;
    end
  end

endmodule

// File: design/pbp_boris.sv
// Boris velocity update: half kick, rotation by t and s, second half kick.
// Six register stages: a multiply or one or two add-saturates. Uses pbp_pkg.
module pbp_boris (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  pbp_pkg::side_t   s_in,
  input  pbp_pkg::efield_t ex,
  input  pbp_pkg::efield_t ey,
  input  pbp_pkg::coef_t   kick,
  input  pbp_pkg::coef_t   rot_t,
  input  pbp_pkg::coef_t   rot_s,
  output pbp_pkg::side_t   s_out,
  output pbp_pkg::vel_t    nvx,
  output pbp_pkg::vel_t    nvy
);
  import pbp_pkg::*;

  side_t              s4, s5, s6, s7, s8;
  kick_t              hx4, hy4, hx5, hy5, hx6, hy6, hx7, hy7, hx8, hy8;
  vel_t               mx5, my5, mx6, my6, mx7, my7, mx8, my8;
  logic signed [47:0] pyt6, pxt6, pys8, pxs8;
  vel_t               qx7, qy7;
  logic signed [48:0] kx, ky;
  logic signed [47:0] ryt, rxt, rys, rxs;
  vel_t               nx, ny;
  vel_t               nvx_next, nvy_next;

  always_comb begin
    kx = (kick * ex) + 49'sd2097152;
    ky = (kick * ey) + 49'sd2097152;
    ryt = pyt6 + 48'sd2097152;
    rxt = pxt6 + 48'sd2097152;
    rys = pys8 + 48'sd2097152;
    rxs = pxs8 + 48'sd2097152;
    nx = sat24(28'(mx8) + 28'($signed(rys[47:22])));
    ny = sat24(28'(my8) - 28'($signed(rxs[47:22])));
    nvx_next = sat24(28'(nx) + 28'(hx8));
    nvy_next = sat24(28'(ny) + 28'(hy8));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s4.vld    <= 1'b0;
      s5.vld    <= 1'b0;
      s6.vld    <= 1'b0;
      s7.vld    <= 1'b0;
      s8.vld    <= 1'b0;
      s_out.vld <= 1'b0;
    end else if (en) begin
      s4  <= s_in;
      hx4 <= kx[48:22];
      hy4 <= ky[48:22];
      s5  <= s4;
      hx5 <= hx4;
      hy5 <= hy4;
      mx5 <= sat24(28'(s4.vx) + 28'(hx4));
      my5 <= sat24(28'(s4.vy) + 28'(hy4));
      s6   <= s5;
      hx6  <= hx5;
      hy6  <= hy5;
      mx6  <= mx5;
      my6  <= my5;
      pyt6 <= my5 * rot_t;
      pxt6 <= mx5 * rot_t;
      s7  <= s6;
      hx7 <= hx6;
      hy7 <= hy6;
      mx7 <= mx6;
      my7 <= my6;
      qx7 <= sat24(28'(mx6) + 28'($signed(ryt[47:22])));
      qy7 <= sat24(28'(my6) - 28'($signed(rxt[47:22])));
      s8   <= s7;
      hx8  <= hx7;
      hy8  <= hy7;
      mx8  <= mx7;
      my8  <= my7;
      pys8 <= qy7 * rot_s;
      pxs8 <= qx7 * rot_s;
      s_out <= s8;
      nvx   <= nvx_next;
      nvy   <= nvy_next;
    end
  end

endmodule

// File: design/particle_boris_push_2d.sv
// Push words pass the front end, gather, Boris, drift and output registers.
// Throughput: one word per cycle; the whole pipeline advances whenever the
// output register is empty or being taken, and load words cost one slot.
// The four field reads per push come from four copies of the field store.
// Reset (rst, synchronous) clears the valid bits and the coefficients; the
// field store is not cleared and must be loaded before pushes read it.
module particle_boris_push_2d #(
  parameter int CELLS_X = 64,
  parameter int CELLS_Y = 64
) (
  input logic       clk,
  input logic       rst,
  pbp_in_if.sink    push_in,
  pbp_out_if.source push_out,
  pbp_cfg_if.sink   cfg
);
  import pbp_pkg::*;

  localparam int NODES_Y = CELLS_Y + 1;
  localparam int DEPTH   = (CELLS_X + 1) * NODES_Y;
  localparam int AW      = $clog2(DEPTH);
  localparam int LEN_X   = CELLS_X * FRAC_ONE;
  localparam int LEN_Y   = CELLS_Y * FRAC_ONE;
  localparam int CXW     = $clog2(CELLS_X);
  localparam int CYW     = $clog2(CELLS_Y);
  localparam logic signed [27:0] LX = 28'(LEN_X);
  localparam logic signed [27:0] LY = 28'(LEN_Y);

  coef_t  kick, rot_t, rot_s;
  ucoef_t drift;

  logic adv, acc;
  assign adv = !push_out.valid || push_out.ready;
  assign push_in.ready = adv;
  assign acc = push_in.valid && adv;
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      kick  <= '0;
      drift <= '0;
      rot_t <= '0;
      rot_s <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_KICK:  kick  <= cfg.data;
        REG_DRIFT: drift <= cfg.data;
        REG_ROT_T: rot_t <= cfg.data;
        REG_ROT_S: rot_s <= cfg.data;
        default: ;
      endcase
    end
  end

  // Front end: clamp, locate cell and fraction, form the four node addresses.
  pos_t        pxc, pyc;
  logic [31:0] cx, cy, ci, cj, anode;
  frac_t       di_n, dj_n;
  logic [AW-1:0] ra, ra1, rb, rb1, waddr;
  logic        we;
  field_pair_t wdata;

  always_comb begin
    pxc = push_in.pos_x;
    pyc = push_in.pos_y;
    if ({9'b0, push_in.pos_x} > 32'(LEN_X)) begin
      pxc = 23'(LEN_X);
    end
    if ({9'b0, push_in.pos_y} > 32'(LEN_Y)) begin
      pyc = 23'(LEN_Y);
    end
    cx = {25'b0, pxc[22:16]};
    cy = {25'b0, pyc[22:16]};
    // A position on the upper edge uses the last cell at full fraction.
    if (cx >= 32'(CELLS_X)) begin
      ci   = 32'(CELLS_X - 1);
      di_n = 17'(FRAC_ONE);
    end else begin
      ci   = cx;
      di_n = {1'b0, pxc[15:0]};
    end
    if (cy >= 32'(CELLS_Y)) begin
      cj   = 32'(CELLS_Y - 1);
      dj_n = 17'(FRAC_ONE);
    end else begin
      cj   = cy;
      dj_n = {1'b0, pyc[15:0]};
    end
    anode = ci * 32'(NODES_Y) + cj;
    ra  = anode[AW-1:0];
    ra1 = AW'(anode + 32'd1);
    rb  = AW'(anode + 32'(NODES_Y));
    rb1 = AW'(anode + 32'(NODES_Y + 1));
    we  = acc && (push_in.op == OP_LOAD) && ({19'b0, push_in.node_index} < 32'(DEPTH));
    waddr = AW'(push_in.node_index);
    wdata.fx = push_in.field_x_in;
    wdata.fy = push_in.field_y_in;
  end

  field_pair_t f_a, f_a1, f_b, f_b1;

  pbp_field_bank #(.DEPTH(DEPTH), .AW(AW)) u_bank_a (
    .clk(clk), .en(adv), .we(we), .waddr(waddr), .wdata(wdata), .raddr(ra), .rdata(f_a));
  pbp_field_bank #(.DEPTH(DEPTH), .AW(AW)) u_bank_a1 (
    .clk(clk), .en(adv), .we(we), .waddr(waddr), .wdata(wdata), .raddr(ra1), .rdata(f_a1));
  pbp_field_bank #(.DEPTH(DEPTH), .AW(AW)) u_bank_b (
    .clk(clk), .en(adv), .we(we), .waddr(waddr), .wdata(wdata), .raddr(rb), .rdata(f_b));
  pbp_field_bank #(.DEPTH(DEPTH), .AW(AW)) u_bank_b1 (
    .clk(clk), .en(adv), .we(we), .waddr(waddr), .wdata(wdata), .raddr(rb1), .rdata(f_b1));

  side_t s1;
  frac_t di1, dj1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.vld <= 1'b0;
    end else if (adv) begin
      s1.vld  <= acc && (push_in.op == OP_PUSH);
      s1.px   <= pxc;
      s1.py   <= pyc;
      s1.vx   <= push_in.vel_x;
      s1.vy   <= push_in.vel_y;
      s1.last <= push_in.last_in;
      di1     <= di_n;
      dj1     <= dj_n;
    end
  end

  side_t   s3, s9;
  efield_t ex3, ey3;
  vel_t    nvx9, nvy9;

  pbp_gather u_gather (
    .clk(clk), .rst(rst), .en(adv), .s_in(s1), .di(di1), .dj(dj1),
    .f_a(f_a), .f_a1(f_a1), .f_b(f_b), .f_b1(f_b1),
    .s_out(s3), .ex(ex3), .ey(ey3));

  pbp_boris u_boris (
    .clk(clk), .rst(rst), .en(adv), .s_in(s3), .ex(ex3), .ey(ey3),
    .kick(kick), .rot_t(rot_t), .rot_s(rot_s),
    .s_out(s9), .nvx(nvx9), .nvy(nvy9));

  // Drift and periodic wrap. Moves are below 2^23, so the excess over the
  // domain spans at most 128 cell widths and a small remainder table suffices.
  logic [CXW-1:0] mod_x [128];
  logic [CYW-1:0] mod_y [128];

  for (genvar k = 0; k < 128; k++) begin : g_mod
    assign mod_x[k] = CXW'(k % CELLS_X);
    assign mod_y[k] = CYW'(k % CELLS_Y);
  end

  side_t              s10, s11;
  vel_t               nvx10, nvy10, nvx11, nvy11;
  logic signed [48:0] pdx, pdy, rdx, rdy;
  logic signed [27:0] sx, sy, ux, uy;
  logic               negx, negy, ovx, ovy;
  logic               negx11, negy11, ovx11, ovy11;
  logic [6:0]         hix11, hiy11;
  logic [15:0]        lox11, loy11;
  pos_t               sx11, sy11;
  logic [27:0]        remx, remy;
  pos_t               posx_next, posy_next;

  always_comb begin
    rdx = pdx + 49'sd8388608;
    rdy = pdy + 49'sd8388608;
    sx = $signed({5'b0, s10.px}) + 28'($signed(rdx[48:24]));
    sy = $signed({5'b0, s10.py}) + 28'($signed(rdy[48:24]));
    negx = sx < 28'sd0;
    negy = sy < 28'sd0;
    ovx = sx > LX;
    ovy = sy > LY;
    ux = '0;
    uy = '0;
    if (negx) begin
      ux = -sx;
    end else if (ovx) begin
      ux = sx - 28'sd1 - LX;
    end
    if (negy) begin
      uy = -sy;
    end else if (ovy) begin
      uy = sy - 28'sd1 - LY;
    end
  end

  always_comb begin
    remx = (28'(mod_x[hix11]) << 16) | 28'(lox11);
    remy = (28'(mod_y[hiy11]) << 16) | 28'(loy11);
    if (negx11) begin
      posx_next = (remx == '0) ? '0 : 23'(LX - $signed(remx));
    end else if (ovx11) begin
      posx_next = 23'(remx + 28'd1);
    end else begin
      posx_next = sx11;
    end
    if (negy11) begin
      posy_next = (remy == '0) ? '0 : 23'(LY - $signed(remy));
    end else if (ovy11) begin
      posy_next = 23'(remy + 28'd1);
    end else begin
      posy_next = sy11;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s10.vld        <= 1'b0;
      s11.vld        <= 1'b0;
      push_out.valid <= 1'b0;
    end else if (adv) begin
      s10   <= s9;
      nvx10 <= nvx9;
      nvy10 <= nvy9;
      pdx   <= nvx9 * $signed({1'b0, drift});
      pdy   <= nvy9 * $signed({1'b0, drift});
      s11    <= s10;
      nvx11  <= nvx10;
      nvy11  <= nvy10;
      negx11 <= negx;
      negy11 <= negy;
      ovx11  <= ovx;
      ovy11  <= ovy;
      hix11  <= ux[22:16];
      hiy11  <= uy[22:16];
      lox11  <= ux[15:0];
      loy11  <= uy[15:0];
      sx11   <= sx[22:0];
      sy11   <= sy[22:0];
      push_out.valid     <= s11.vld;
      push_out.new_pos_x <= posx_next;
      push_out.new_pos_y <= posy_next;
      push_out.new_vel_x <= nvx11;
      push_out.new_vel_y <= nvy11;
      push_out.last_out  <= s11.last;
    end
  end

  a_load_no_result: assert property (@(posedge clk) disable iff (rst)
    (push_in.valid && push_in.ready && push_in.op == OP_LOAD) |=> !s1.vld)
    else $error("load word entered the push pipeline");

  a_stall_holds_front: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(s1) && $stable(s10))
    else $error("pipeline stage changed during a stall");

  a_pos_x_in_domain: assert property (@(posedge clk) disable iff (rst)
    (push_out.valid && LEN_X < 8388608) |-> ({9'b0, push_out.new_pos_x} <= 32'(LEN_X)))
    else $error("wrapped x position outside the domain");

  a_pos_y_in_domain: assert property (@(posedge clk) disable iff (rst)
    (push_out.valid && LEN_Y < 8388608) |-> ({9'b0, push_out.new_pos_y} <= 32'(LEN_Y)))
    else $error("wrapped y position outside the domain");

endmodule

// File: verif/particle_boris_push_2d_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for particle_boris_push_2d: field loads, pushes,
// coefficient writes, random idling on both sides. Depends on pbp_pkg and
// the pbp_in_if / pbp_out_if / pbp_cfg_if interfaces.
module particle_boris_push_2d_tb;
  import pbp_pkg::*;

  localparam int  NCX     = 64;
  localparam int  NCY     = 64;
  localparam int  ROWS    = NCY + 1;
  localparam int  DEPTH   = (NCX + 1) * (NCY + 1);
  localparam int  LEN_X   = NCX * 65536;
  localparam int  LEN_Y   = NCY * 65536;
  localparam int  DRAIN   = 24;
  localparam int  N_RAND  = 1150;
  localparam int  WIN     = 4;

  typedef struct {
    op_t         op;
    logic [12:0] node;
    vel_t        fx;
    vel_t        fy;
    pos_t        px;
    pos_t        py;
    vel_t        vx;
    vel_t        vy;
    logic        last;
  } particle_word_t;

  typedef struct {
    pos_t px;
    pos_t py;
    vel_t vx;
    vel_t vy;
    logic last;
  } push_result_t;

  class boris_scoreboard;
    longint fx_mem[DEPTH];
    longint fy_mem[DEPTH];
    longint kick, drift, rot_t, rot_s;
    push_result_t awaiting[$];
    int errors;
    int checked;

    function void clear_coeffs();
      kick = 0; drift = 0; rot_t = 0; rot_s = 0;
    endfunction

    function void write_coeff(reg_idx_t idx, logic [23:0] d);
      case (idx)
        REG_KICK:  kick  = longint'($signed(d));
        REG_DRIFT: drift = longint'({40'd0, d});
        REG_ROT_T: rot_t = longint'($signed(d));
        REG_ROT_S: rot_s = longint'($signed(d));
        default: ;
      endcase
    endfunction

    function longint round_shift(longint v, int sh);
      longint b;
      b = v + (longint'(1) << (sh - 1));
      return b >>> sh;
    endfunction

    function longint clamp24(longint v);
      if (v > 8388607) return 8388607;
      if (v < -8388608) return -8388608;
      return v;
    endfunction

    function longint wrap_pos(longint p, longint len);
      longint r;
      if (p < 0) begin
        r = (-p) % len;
        return (r == 0) ? 0 : len - r;
      end
      if (p > len) return ((p - 1) % len) + 1;
      return p;
    endfunction

    function longint bilinear(ref longint f[DEPTH], input longint i, longint di,
                              longint j, longint dj);
      longint a, b, acc;
      a = i * ROWS + j;
      b = (i + 1) * ROWS + j;
      acc = f[a] * ((65536 - di) * (65536 - dj)) + f[b] * (di * (65536 - dj))
          + f[a + 1] * ((65536 - di) * dj) + f[b + 1] * (di * dj);
      return round_shift(acc, 32);
    endfunction

    function void note_input(particle_word_t w);
      longint px, py, i, di, j, dj, ex, ey, hx, hy, mx, my, qx, qy, nx, ny;
      push_result_t r;
      if (w.op == OP_LOAD) begin
        if (w.node < DEPTH) begin
          fx_mem[w.node] = longint'(w.fx);
          fy_mem[w.node] = longint'(w.fy);
        end
        return;
      end
      px = w.px; py = w.py;
      if (px > LEN_X) px = LEN_X;
      if (py > LEN_Y) py = LEN_Y;
      // The top edge falls into the last cell with a full fraction.
      i = px >> 16; di = px & 16'hFFFF;
      if (i >= NCX) begin i = NCX - 1; di = 65536; end
      j = py >> 16; dj = py & 16'hFFFF;
      if (j >= NCY) begin j = NCY - 1; dj = 65536; end
      ex = bilinear(fx_mem, i, di, j, dj);
      ey = bilinear(fy_mem, i, di, j, dj);
      hx = round_shift(kick * ex, 22);
      hy = round_shift(kick * ey, 22);
      mx = clamp24(longint'(w.vx) + hx);
      my = clamp24(longint'(w.vy) + hy);
      qx = clamp24(mx + round_shift(my * rot_t, 22));
      qy = clamp24(my - round_shift(mx * rot_t, 22));
      nx = clamp24(mx + round_shift(qy * rot_s, 22));
      ny = clamp24(my - round_shift(qx * rot_s, 22));
      nx = clamp24(nx + hx);
      ny = clamp24(ny + hy);
      r.px = pos_t'(wrap_pos(px + round_shift(nx * drift, 24), LEN_X));
      r.py = pos_t'(wrap_pos(py + round_shift(ny * drift, 24), LEN_Y));
      r.vx = vel_t'(nx);
      r.vy = vel_t'(ny);
      r.last = w.last;
      awaiting.push_back(r);
    endfunction

    function void check_result(push_result_t got);
      push_result_t e;
      checked++;
      if (awaiting.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result word: pos %0d,%0d", got.px, got.py);
        return;
      end
      e = awaiting.pop_front();
      if (got.px !== e.px || got.py !== e.py || got.vx !== e.vx || got.vy !== e.vy ||
          got.last !== e.last) begin
        errors++;
        if (errors <= 10)
          $display({"mismatch #%0d: exp pos %0d,%0d vel %0d,%0d last %0b;",
                    " got pos %0d,%0d vel %0d,%0d last %0b"},
                   checked, e.px, e.py, e.vx, e.vy, e.last,
                   got.px, got.py, got.vx, got.vy, got.last);
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  bit   no_idle;
  int   pushes_sent, loads_sent;
  boris_scoreboard sb;

  pbp_in_if  push_in();
  pbp_out_if push_out();
  pbp_cfg_if cfg();

  particle_boris_push_2d #(.CELLS_X(NCX), .CELLS_Y(NCY)) DUT (
    .clk(clk), .rst(rst), .push_in(push_in), .push_out(push_out), .cfg(cfg)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic bit roll_idle();
    return !no_idle && ($urandom_range(0, 99) < 29);
  endfunction

  // Result side: check each taken word, then stall at random.
  always @(posedge clk) begin
    if (!rst && push_out.valid && push_out.ready)
      sb.check_result('{push_out.new_pos_x, push_out.new_pos_y, push_out.new_vel_x,
                        push_out.new_vel_y, push_out.last_out});
    push_out.ready <= rst ? 1'b0 : !roll_idle();
  end

  task automatic send_word(particle_word_t w);
    while (roll_idle()) begin
      push_in.valid <= 1'b0;
      @(posedge clk);
    end
    push_in.op <= w.op;
    push_in.node_index <= w.node;
    push_in.field_x_in <= w.fx;
    push_in.field_y_in <= w.fy;
    push_in.pos_x <= w.px;
    push_in.pos_y <= w.py;
    push_in.vel_x <= w.vx;
    push_in.vel_y <= w.vy;
    push_in.last_in <= w.last;
    push_in.valid <= 1'b1;
    @(posedge clk);
    while (!push_in.ready) @(posedge clk);
    sb.note_input(w);
    if (w.op == OP_PUSH) pushes_sent++; else loads_sent++;
  endtask

  task automatic wait_idle();
    push_in.valid <= 1'b0;
    while (sb.awaiting.size() != 0) @(posedge clk);
    // Trailing load words may still be in flight.
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [23:0] d);
    cfg.index <= idx;
    cfg.data <= d;
    cfg.valid <= 1'b1;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    sb.write_coeff(idx, d);
  endtask

  task automatic set_coeffs(logic [23:0] k, logic [23:0] d, logic [23:0] t, logic [23:0] s);
    write_reg(REG_KICK, k);
    write_reg(REG_DRIFT, d);
    write_reg(REG_ROT_T, t);
    write_reg(REG_ROT_S, s);
    cfg.valid <= 1'b0;
  endtask

  function automatic particle_word_t load_word(int node, vel_t fx, vel_t fy);
    particle_word_t w;
    w = '{OP_LOAD, 13'(node), fx, fy, pos_t'($urandom), pos_t'($urandom),
          vel_t'($urandom), vel_t'($urandom), 1'($urandom)};
    return w;
  endfunction

  function automatic particle_word_t push_word(pos_t px, pos_t py, vel_t vx, vel_t vy,
                                               logic last);
    particle_word_t w;
    w = '{OP_PUSH, 13'($urandom), vel_t'($urandom), vel_t'($urandom), px, py, vx, vy, last};
    return w;
  endfunction

  // Pushes stay in the cells next to the grid edges, whose nodes are loaded first.
  function automatic pos_t rand_pos(int len);
    int m;
    m = $urandom_range(0, 99);
    if (m < 41) return pos_t'($urandom_range(0, WIN * 65536 - 1));
    if (m < 82) return pos_t'($urandom_range(len - WIN * 65536, len));
    if (m < 88) return pos_t'(len);
    if (m < 92) return '0;
    return pos_t'($urandom_range(len + 1, 23'h7FFFFF));
  endfunction

  function automatic bit near_edge(int c, int cells);
    return (c <= WIN) || (c >= cells - WIN);
  endfunction

  function automatic vel_t rand_vel();
    int m;
    m = $urandom_range(0, 9);
    if (m == 0) return 24'sh7FFFFF;
    if (m == 1) return 24'sh800000;
    if (m < 5) return vel_t'($signed(24'($urandom_range(0, 1 << 18)) - 24'd131072));
    return vel_t'($urandom);
  endfunction

  function automatic particle_word_t rand_word();
    if ($urandom_range(0, 99) < 25) begin
      if ($urandom_range(0, 9) == 0)
        return load_word($urandom_range(DEPTH, 8191), vel_t'($urandom), vel_t'($urandom));
      return load_word($urandom_range(0, DEPTH - 1), vel_t'($urandom), vel_t'($urandom));
    end
    return push_word(rand_pos(LEN_X), rand_pos(LEN_Y), rand_vel(), rand_vel(), 1'($urandom));
  endfunction

  initial begin
    logic [23:0] phase_cfg[5][4];
    sb = new();
    sb.clear_coeffs();
    no_idle = 1'b0;
    pushes_sent = 0;
    loads_sent = 0;
    rst <= 1'b1;
    push_in.valid <= 1'b0;
    push_in.op <= OP_LOAD;
    push_in.node_index <= '0;
    push_in.field_x_in <= '0;
    push_in.field_y_in <= '0;
    push_in.pos_x <= '0;
    push_in.pos_y <= '0;
    push_in.vel_x <= '0;
    push_in.vel_y <= '0;
    push_in.last_in <= 1'b0;
    cfg.valid <= 1'b0;
    cfg.index <= REG_KICK;
    cfg.data <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Load every node in the four corner regions; every push lands in one of those
    // cells, so no push reads an unwritten node.
    for (int c = 0; c <= NCX; c++)
      for (int r = 0; r <= NCY; r++)
        if (near_edge(c, NCX) && near_edge(r, NCY))
          send_word(load_word(c * ROWS + r,
                              vel_t'($signed(24'($urandom_range(0, 1 << 20)) - 24'd524288)),
                              vel_t'($signed(24'($urandom_range(0, 1 << 20)) - 24'd524288))));

    // Directed part with the strongest coefficients.
    wait_idle();
    set_coeffs(24'h7FFFFF, 24'hFFFFFF, 24'h800000, 24'h7FFFFF);
    send_word(load_word(0, 24'sh7FFFFF, 24'sh800000));
    send_word(load_word(DEPTH - 1, 24'sh800000, 24'sh7FFFFF));
    send_word(load_word(DEPTH, 24'sh7FFFFF, 24'sh7FFFFF));
    send_word(load_word(8191, 24'sh800000, 24'sh800000));
    send_word(push_word('0, '0, '0, '0, 1'b0));
    send_word(push_word(pos_t'(LEN_X), pos_t'(LEN_Y), 24'sh7FFFFF, 24'sh7FFFFF, 1'b1));
    send_word(push_word(23'h7FFFFF, 23'h7FFFFF, 24'sh800000, 24'sh800000, 1'b0));
    send_word(push_word(23'h00FFFF, 23'h00FFFF, 24'sh800000, 24'sh7FFFFF, 1'b1));
    send_word(push_word(pos_t'(LEN_X - 1), 23'd1, 24'sh7FFFFF, 24'sh800000, 1'b0));
    send_word(push_word(23'd1, pos_t'(LEN_Y - 1), 24'sh800000, 24'sh7FFFFF, 1'b1));
    send_word(push_word(23'd65536, 23'd65536, 24'sh000001, 24'shFFFFFF, 1'b0));
    send_word(push_word(pos_t'(LEN_X + 1), pos_t'(LEN_Y + 1), 24'sh400000, 24'shC00000, 1'b1));

    phase_cfg[0] = '{24'h7FFFFF, 24'hFFFFFF, 24'h7FFFFF, 24'h800000};
    phase_cfg[1] = '{24'h800000, 24'h000000, 24'h800000, 24'h800000};
    phase_cfg[2] = '{24'h400000, 24'h100000, 24'h040000, 24'h07FFFF};
    phase_cfg[3] = '{24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom)};
    phase_cfg[4] = '{24'($urandom), 24'($urandom_range(0, 1 << 20)),
                     24'($urandom_range(0, 1 << 19)), 24'($urandom_range(0, 1 << 20))};
    for (int p = 0; p < 5; p++) begin
      wait_idle();
      set_coeffs(phase_cfg[p][0], phase_cfg[p][1], phase_cfg[p][2], phase_cfg[p][3]);
      for (int k = 0; k < N_RAND / 5; k++) begin
        no_idle = (p == 2) && (k >= 40) && (k < 180);
        // Let the pipeline run completely dry once in mid-stream.
        if (p == 3 && k == 100) begin
          push_in.valid <= 1'b0;
          do @(posedge clk); while (sb.awaiting.size() != 0);
        end
        send_word(rand_word());
      end
      no_idle = 1'b0;
    end

    push_in.valid <= 1'b0;
    while (sb.awaiting.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    $display("Covered %0d pushes and %0d field loads over six coefficient settings.",
             pushes_sent, loads_sent);
    $display("%0d result words checked, %0d mismatches.", sb.checked, sb.errors);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
